// File: src/twsc_pkg.sv
package twsc_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_ENGAGE_DISTANCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_WINDOW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_LOW_EDGE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_HIGH_EDGE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_STEP        = 3'd4;

  // Configuration reset values
  localparam logic [7:0] ENGAGE_DISTANCE_RST = 8'd3;
  localparam logic [7:0] TAP_WINDOW_RST      = 8'd3;
  localparam logic [7:0] TAP_LOW_EDGE_RST    = 8'd8;
  localparam logic [7:0] TAP_HIGH_EDGE_RST   = 8'd16;
  localparam logic [9:0] TAP_STEP_RST        = 10'd4;

  localparam int unsigned SETPOINT_RST = 500;

  typedef enum logic [1:0] {
    PWR_OFF   = 2'd0,
    PWR_ON    = 2'd1,
    PWR_FIXED = 2'd2
  } power_mode_e;

  typedef enum logic [1:0] {
    QTY_VOLTS = 2'd0,
    QTY_AMPS  = 2'd1,
    QTY_WATTS = 2'd2
  } quantity_mode_e;

  // One result beat
  typedef struct packed {
    logic [9:0]     dac_code;
    logic           dac_write;
    power_mode_e    power_state;
    quantity_mode_e display_quantity;
  } result_t;

endpackage

// File: src/twsc_out_buf.sv
// Two-entry output buffer: a head register and a skid register, so the
// producer keeps moving while a result waits on the consumer.
module twsc_out_buf
  import twsc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    push_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  result_t head_q, head_d, skid_q, skid_d;
  logic    head_valid_q, head_valid_d, skid_valid_q, skid_valid_d;
  logic    pop;

  assign pop          = head_valid_q & out_ready_i;
  assign push_ready_o = ~skid_valid_q;
  assign out_valid_o  = head_valid_q;
  assign out_data_o   = head_q;

  // Buffer next state (push only arrives while skid is empty)
  always_comb begin
    head_d       = head_q;
    skid_d       = skid_q;
    head_valid_d = head_valid_q;
    skid_valid_d = skid_valid_q;
    if (push_i && pop) begin
      head_d = push_data_i;
    end else if (push_i) begin
      if (!head_valid_q) begin
        head_d       = push_data_i;
        head_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      if (skid_valid_q) begin
        head_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        head_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

endmodule

// File: src/touch_wheel_setpoint_control_top.sv
// Touch wheel setpoint controller. One touch scan per input beat gives exactly
// one result beat; a new scan is taken every clock cycle, and each result is
// registered into a two-entry output buffer, so the input stalls only when two
// results are waiting. The scan is folded into the control state by
// combinational compare, add and clamp logic. Configuration writes take effect
// at once and must be made while no scan is in flight.
module touch_wheel_setpoint_control_top
  import twsc_pkg::*;
#(
  parameter int unsigned CODE_MAX      = 1023,
  parameter int unsigned POSITION_BITS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // scan input
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     touch_valid_i,
  input  logic [POSITION_BITS-1:0] touch_position_i,
  input  logic                     power_pad_i,
  input  logic                     quantity_pad_i,
  // result output
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [9:0]               dac_code_o,
  output logic                     dac_write_o,
  output logic [1:0]               power_state_o,
  output logic [1:0]               display_quantity_o,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned SP_W  = $clog2(CODE_MAX + 1);
  localparam int unsigned PW    = POSITION_BITS;
  localparam int unsigned CMP_W = (PW > 8) ? PW : 8;
  localparam int unsigned MX_W  = (SP_W > PW) ? ((SP_W > 10) ? SP_W : 10)
                                              : ((PW > 10) ? PW : 10);
  localparam int unsigned SUM_W = MX_W + 2;
  localparam int unsigned SP_RST_VAL = (SETPOINT_RST > CODE_MAX) ? CODE_MAX : SETPOINT_RST;
  localparam logic [SP_W-1:0]         SP_RST = SP_W'(SP_RST_VAL);
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(CODE_MAX);

  // Configuration registers
  logic [7:0] engage_distance_q, tap_window_q, tap_low_edge_q, tap_high_edge_q;
  logic [9:0] tap_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      engage_distance_q <= ENGAGE_DISTANCE_RST;
      tap_window_q      <= TAP_WINDOW_RST;
      tap_low_edge_q    <= TAP_LOW_EDGE_RST;
      tap_high_edge_q   <= TAP_HIGH_EDGE_RST;
      tap_step_q        <= TAP_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ENGAGE_DISTANCE: engage_distance_q <= cfg_wdata_i[7:0];
        CFG_TAP_WINDOW:      tap_window_q      <= cfg_wdata_i[7:0];
        CFG_TAP_LOW_EDGE:    tap_low_edge_q    <= cfg_wdata_i[7:0];
        CFG_TAP_HIGH_EDGE:   tap_high_edge_q   <= cfg_wdata_i[7:0];
        CFG_TAP_STEP:        tap_step_q        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Control state
  logic           awaiting_q, awaiting_d;
  logic [PW-1:0]  start_q, start_d, last_q, last_d;
  logic           engaged_q, engaged_d;
  logic [SP_W-1:0] sp_q, sp_d;
  power_mode_e    power_q, power_d;
  quantity_mode_e qty_q, qty_d;
  logic           ppad_held_q, ppad_held_d, qpad_held_q, qpad_held_d;
  logic           write;

  logic           accept, buf_ready;
  logic [PW-1:0]  start_eff, last_eff, pos_dist, tap_dist;
  logic           far;
  logic signed [PW:0]      delta;
  logic signed [SUM_W-1:0] sum;
  logic           tap_ok;
  power_mode_e    power_next;
  quantity_mode_e qty_next;

  assign in_ready_o = buf_ready;
  assign accept     = in_valid_i & buf_ready;

  // Touch distances and slide delta
  always_comb begin
    start_eff = awaiting_q ? touch_position_i : start_q;
    last_eff  = awaiting_q ? touch_position_i : last_q;
    pos_dist  = (touch_position_i > start_eff) ? (touch_position_i - start_eff)
                                              : (start_eff - touch_position_i);
    tap_dist  = (start_q > last_q) ? (start_q - last_q) : (last_q - start_q);
    far       = CMP_W'(pos_dist) > CMP_W'(engage_distance_q);
    tap_ok    = (power_q == PWR_ON) && !awaiting_q &&
                (CMP_W'(tap_dist) < CMP_W'(tap_window_q));
    delta     = $signed({1'b0, last_eff}) - $signed({1'b0, touch_position_i});
  end

  // Setpoint and touch tracking
  always_comb begin
    awaiting_d = awaiting_q;
    start_d    = start_q;
    last_d     = last_q;
    engaged_d  = engaged_q;
    sp_d       = sp_q;
    write      = 1'b0;
    sum        = $signed({{(SUM_W-SP_W){1'b0}}, sp_q});
    if (touch_valid_i) begin
      awaiting_d = 1'b0;
      start_d    = start_eff;
      last_d     = touch_position_i;
      engaged_d  = engaged_q | far;
      if (power_q != PWR_FIXED && (engaged_q || far)) begin
        sum = sum + SUM_W'(delta);
      end
      write = 1'b1;
    end else begin
      if (tap_ok && CMP_W'(start_q) < CMP_W'(tap_low_edge_q)) begin
        sum   = sum + $signed({{(SUM_W-10){1'b0}}, tap_step_q});
        write = 1'b1;
      end else if (tap_ok && CMP_W'(start_q) > CMP_W'(tap_high_edge_q)) begin
        sum   = sum - $signed({{(SUM_W-10){1'b0}}, tap_step_q});
        write = 1'b1;
      end
      awaiting_d = 1'b1;
      engaged_d  = 1'b0;
    end
    // saturate to the code range
    if (sum < 0) begin
      sp_d = '0;
    end else if (sum > SUM_MAX) begin
      sp_d = SP_W'(CODE_MAX);
    end else begin
      sp_d = sum[SP_W-1:0];
    end
  end

  // Pad press edges cycle the modes
  always_comb begin
    case (power_q)
      PWR_OFF: power_next = PWR_ON;
      PWR_ON:  power_next = PWR_FIXED;
      default: power_next = PWR_OFF;
    endcase
    case (qty_q)
      QTY_VOLTS: qty_next = QTY_AMPS;
      QTY_AMPS:  qty_next = QTY_WATTS;
      default:   qty_next = QTY_VOLTS;
    endcase
    power_d     = (power_pad_i && !ppad_held_q) ? power_next : power_q;
    qty_d       = (quantity_pad_i && !qpad_held_q) ? qty_next : qty_q;
    ppad_held_d = power_pad_i;
    qpad_held_d = quantity_pad_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q  <= 1'b1;
      start_q     <= '0;
      last_q      <= '0;
      engaged_q   <= 1'b0;
      sp_q        <= SP_RST;
      power_q     <= PWR_OFF;
      qty_q       <= QTY_VOLTS;
      ppad_held_q <= 1'b0;
      qpad_held_q <= 1'b0;
    end else if (accept) begin
      awaiting_q  <= awaiting_d;
      start_q     <= start_d;
      last_q      <= last_d;
      engaged_q   <= engaged_d;
      sp_q        <= sp_d;
      power_q     <= power_d;
      qty_q       <= qty_d;
      ppad_held_q <= ppad_held_d;
      qpad_held_q <= qpad_held_d;
    end
  end

  // Result beat
  result_t res, out_res;

  always_comb begin
    res.dac_code         = 10'(sp_d);
    res.dac_write        = write;
    res.power_state      = power_d;
    res.display_quantity = qty_d;
  end

  twsc_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept),
    .push_data_i  (res),
    .push_ready_o (buf_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_res)
  );

  assign dac_code_o         = out_res.dac_code;
  assign dac_write_o        = out_res.dac_write;
  assign power_state_o      = out_res.power_state;
  assign display_quantity_o = out_res.display_quantity;

endmodule

// File: dv/touch_wheel_setpoint_control_top_tb.sv
localparam int DAC_CODE_MAX = 1023;

// Tracks the controller state and holds the results it should produce, in order
class setpoint_scoreboard;
  // register copies
  logic [7:0] engage_dist;
  logic [7:0] tap_window;
  logic [7:0] low_edge;
  logic [7:0] high_edge;
  logic [9:0] tap_step;

  // control state
  bit                        awaiting_first;
  logic [7:0]                start_pos;
  logic [7:0]                last_pos;
  bit                        engaged;
  logic [9:0]                setpoint;
  twsc_pkg::power_mode_e     pwr;
  twsc_pkg::quantity_mode_e  qty;
  bit                        ppad_held;
  bit                        qpad_held;

  twsc_pkg::result_t expected_q[$];
  int                errors;
  int                results_seen;

  function new();
    engage_dist    = twsc_pkg::ENGAGE_DISTANCE_RST;
    tap_window     = twsc_pkg::TAP_WINDOW_RST;
    low_edge       = twsc_pkg::TAP_LOW_EDGE_RST;
    high_edge      = twsc_pkg::TAP_HIGH_EDGE_RST;
    tap_step       = twsc_pkg::TAP_STEP_RST;
    awaiting_first = 1'b1;
    start_pos      = '0;
    last_pos       = '0;
    engaged        = 1'b0;
    setpoint       = (twsc_pkg::SETPOINT_RST > DAC_CODE_MAX) ?
                     10'(DAC_CODE_MAX) : 10'(twsc_pkg::SETPOINT_RST);
    pwr            = twsc_pkg::PWR_OFF;
    qty            = twsc_pkg::QTY_VOLTS;
    ppad_held      = 1'b0;
    qpad_held      = 1'b0;
    errors         = 0;
    results_seen   = 0;
  endfunction

  function void set_reg(logic [twsc_pkg::CFG_IDX_W-1:0] idx, logic [9:0] data);
    case (idx)
      twsc_pkg::CFG_ENGAGE_DISTANCE: engage_dist = data[7:0];
      twsc_pkg::CFG_TAP_WINDOW:      tap_window  = data[7:0];
      twsc_pkg::CFG_TAP_LOW_EDGE:    low_edge    = data[7:0];
      twsc_pkg::CFG_TAP_HIGH_EDGE:   high_edge   = data[7:0];
      twsc_pkg::CFG_TAP_STEP:        tap_step    = data;
      default: ;
    endcase
  endfunction

  function int abs_diff(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function logic [9:0] saturate(int v);
    if (v < 0) return '0;
    if (v > DAC_CODE_MAX) return 10'(DAC_CODE_MAX);
    return 10'(v);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Fold one accepted scan into the state and queue the result it gives
  function void note_scan(bit touch, logic [7:0] pos, bit ppad, bit qpad);
    int                delta;
    bit                wr;
    twsc_pkg::result_t r;
    wr = 1'b0;
    if (touch) begin
      if (awaiting_first) begin
        start_pos      = pos;
        last_pos       = pos;
        awaiting_first = 1'b0;
      end
      if (abs_diff(int'(pos), int'(start_pos)) > int'(engage_dist)) engaged = 1'b1;
      delta = int'(last_pos) - int'(pos);
      // no slide when fixed or before the finger has moved far enough
      if (pwr == twsc_pkg::PWR_FIXED || !engaged) delta = 0;
      last_pos = pos;
      setpoint = saturate(int'(setpoint) + delta);
      wr       = 1'b1;
    end else begin
      // lift: a short touch in the on state may nudge the setpoint
      if (pwr == twsc_pkg::PWR_ON && !awaiting_first &&
          abs_diff(int'(start_pos), int'(last_pos)) < int'(tap_window)) begin
        if (start_pos < low_edge) begin
          setpoint = saturate(int'(setpoint) + int'(tap_step));
          wr       = 1'b1;
        end else if (start_pos > high_edge) begin
          setpoint = saturate(int'(setpoint) - int'(tap_step));
          wr       = 1'b1;
        end
      end
      awaiting_first = 1'b1;
      engaged        = 1'b0;
    end

    // pads act on press edges only
    if (ppad) begin
      if (!ppad_held) begin
        ppad_held = 1'b1;
        case (pwr)
          twsc_pkg::PWR_OFF: pwr = twsc_pkg::PWR_ON;
          twsc_pkg::PWR_ON:  pwr = twsc_pkg::PWR_FIXED;
          default:           pwr = twsc_pkg::PWR_OFF;
        endcase
      end
    end else begin
      ppad_held = 1'b0;
    end
    if (qpad) begin
      if (!qpad_held) begin
        qpad_held = 1'b1;
        case (qty)
          twsc_pkg::QTY_VOLTS: qty = twsc_pkg::QTY_AMPS;
          twsc_pkg::QTY_AMPS:  qty = twsc_pkg::QTY_WATTS;
          default:             qty = twsc_pkg::QTY_VOLTS;
        endcase
      end
    end else begin
      qpad_held = 1'b0;
    end

    r.dac_code         = setpoint;
    r.dac_write        = wr;
    r.power_state      = pwr;
    r.display_quantity = qty;
    expected_q.push_back(r);
  endfunction

  task report_mismatch(string msg);
    $display("[%0t] mismatch on result beat %0d: %s", $time, results_seen, msg);
    errors++;
  endtask

  // Compare one accepted result beat with the oldest expectation
  task check_result(logic [9:0] code, logic wr, logic [1:0] ps, logic [1:0] dq);
    twsc_pkg::result_t e;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected beat, dac_code %0d", code));
      results_seen++;
      return;
    end
    e = expected_q.pop_front();
    if (code !== e.dac_code)
      report_mismatch($sformatf("dac_code %0d, want %0d", code, e.dac_code));
    if (wr !== e.dac_write)
      report_mismatch($sformatf("dac_write %0b, want %0b", wr, e.dac_write));
    if (ps !== e.power_state)
      report_mismatch($sformatf("power_state %0d, want %0d", ps, e.power_state));
    if (dq !== e.display_quantity)
      report_mismatch($sformatf("display_quantity %0d, want %0d", dq, e.display_quantity));
    results_seen++;
  endtask
endclass

module touch_wheel_setpoint_control_top_tb;
  import twsc_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int PHASE_SCANS  = 300;
  localparam int PHASE_COUNT  = 6;

  logic                  clk_i              = 1'b0;
  logic                  rst_ni             = 1'b0;
  logic                  in_valid_i         = 1'b0;
  logic                  in_ready_o;
  logic                  touch_valid_i      = 1'b0;
  logic [7:0]            touch_position_i   = '0;
  logic                  power_pad_i        = 1'b0;
  logic                  quantity_pad_i     = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i        = 1'b0;
  logic [9:0]            dac_code_o;
  logic                  dac_write_o;
  logic [1:0]            power_state_o;
  logic [1:0]            display_quantity_o;
  logic                  cfg_we_i           = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i        = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i        = '0;

  setpoint_scoreboard sb = new();

  int unsigned sender_gap_pct     = 0;
  int unsigned receiver_stall_pct = 0;
  int          stall_cycles       = 0;
  int          scans_sent         = 0;
  bit          pad_power          = 1'b0;
  bit          pad_qty            = 1'b0;

  touch_wheel_setpoint_control_top u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .touch_valid_i      (touch_valid_i),
    .touch_position_i   (touch_position_i),
    .power_pad_i        (power_pad_i),
    .quantity_pad_i     (quantity_pad_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .dac_code_o         (dac_code_o),
    .dac_write_o        (dac_write_o),
    .power_state_o      (power_state_o),
    .display_quantity_o (display_quantity_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Result side back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Beat monitor: values read here are the ones from before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.note_scan(touch_valid_i, touch_position_i, power_pad_i, quantity_pad_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(dac_code_o, dac_write_o, power_state_o, display_quantity_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  // Watchdog: ends a run that stops making progress
  initial begin
    do @(posedge clk_i); while (stall_cycles < STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_scan(bit touch, logic [7:0] pos, bit ppad, bit qpad);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    touch_valid_i    <= touch;
    touch_position_i <= pos;
    power_pad_i      <= ppad;
    quantity_pad_i   <= qpad;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    scans_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [9:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic load_config(logic [7:0] engage, logic [7:0] window, logic [7:0] low,
                             logic [7:0] high, logic [9:0] step);
    write_reg(CFG_ENGAGE_DISTANCE, 10'(engage));
    write_reg(CFG_TAP_WINDOW, 10'(window));
    write_reg(CFG_TAP_LOW_EDGE, 10'(low));
    write_reg(CFG_TAP_HIGH_EDGE, 10'(high));
    write_reg(CFG_TAP_STEP, step);
    cfg_we_i <= 1'b0;
  endtask

  // Stop sending and wait until every expected result has come back; the first
  // edge lets the monitor note the last accepted scan
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  function automatic void toggle_pads();
    if ($urandom_range(0, 99) < 8) pad_power = !pad_power;
    if ($urandom_range(0, 99) < 10) pad_qty = !pad_qty;
  endfunction

  // Mostly one touch: 1 to 6 scans near a start (tap) or wandering (slide), then a lift
  task automatic play_gesture();
    int unsigned kind;
    int unsigned n;
    int          p;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      toggle_pads();
      send_scan(1'($urandom_range(0, 1)), 8'($urandom), pad_power, pad_qty);
      return;
    end
    case ($urandom_range(0, 3))
      0:       p = int'(sb.low_edge) + int'($urandom_range(0, 6)) - 3;
      1:       p = int'(sb.high_edge) + int'($urandom_range(0, 6)) - 3;
      default: p = int'($urandom_range(0, 255));
    endcase
    n = $urandom_range(1, 6);
    for (int j = 0; j < n; j++) begin
      if (j > 0) begin
        if (kind < 6) p += int'($urandom_range(0, 4)) - 2;
        else          p += int'($urandom_range(0, 80)) - 40;
      end
      p = (p < 0) ? 0 : (p > 255) ? 255 : p;
      toggle_pads();
      send_scan(1'b1, 8'(p), pad_power, pad_qty);
    end
    // now and then the finger stays down into the next gesture
    if ($urandom_range(0, 9) != 0) begin
      toggle_pads();
      send_scan(1'b0, 8'($urandom), pad_power, pad_qty);
    end
  endtask

  initial begin
    int target;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: largest tap step so taps hit both clamps
    sender_gap_pct     = 29;
    receiver_stall_pct = 63;
    load_config(ENGAGE_DISTANCE_RST, TAP_WINDOW_RST, TAP_LOW_EDGE_RST, TAP_HIGH_EDGE_RST,
                10'd1023);
    send_scan(1'b0, 8'd255, 1'b0, 1'b0);  // lift with no touch
    send_scan(1'b0, 8'd0, 1'b1, 1'b1);    // power on, amps
    send_scan(1'b0, 8'd0, 1'b1, 1'b1);    // pads held
    send_scan(1'b0, 8'd0, 1'b0, 1'b0);
    send_scan(1'b1, 8'd2, 1'b0, 1'b1);    // low tap, watts
    send_scan(1'b1, 8'd3, 1'b0, 1'b0);
    send_scan(1'b0, 8'd0, 1'b0, 1'b1);    // raise, clamps at top; volts
    send_scan(1'b1, 8'd200, 1'b0, 1'b0);  // high tap
    send_scan(1'b0, 8'd0, 1'b0, 1'b0);    // lower, lands exactly on zero
    send_scan(1'b1, 8'd12, 1'b0, 1'b0);   // tap between the edges
    send_scan(1'b0, 8'd0, 1'b0, 1'b0);
    send_scan(1'b1, 8'd0, 1'b0, 1'b0);    // slide across the wheel
    send_scan(1'b1, 8'd255, 1'b0, 1'b0);
    send_scan(1'b1, 8'd0, 1'b0, 1'b0);
    send_scan(1'b1, 8'd128, 1'b0, 1'b0);
    send_scan(1'b0, 8'd0, 1'b0, 1'b0);    // long touch, no tap
    send_scan(1'b1, 8'd5, 1'b1, 1'b0);    // fixed
    send_scan(1'b1, 8'd250, 1'b1, 1'b0);  // slide blocked
    send_scan(1'b0, 8'd0, 1'b0, 1'b0);
    send_scan(1'b1, 8'd3, 1'b1, 1'b0);    // back to off
    send_scan(1'b0, 8'd0, 1'b0, 1'b0);    // tap ignored when off
    send_scan(1'b1, 8'd255, 1'b1, 1'b1);  // on again
    send_scan(1'b1, 8'd254, 1'b0, 1'b0);
    send_scan(1'b0, 8'd0, 1'b0, 1'b0);    // high tap from the top position
    settle();

    // random phases over several register settings and idle patterns
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: load_config(8'd3, 8'd3, 8'd8, 8'd16, 10'd4);
        1: load_config(8'd0, 8'd255, 8'd255, 8'd0, 10'd1023);
        2: load_config(8'd255, 8'd0, 8'd0, 8'd255, 10'd0);
        3: load_config(8'd10, 8'd20, 8'd100, 8'd150, 10'd37);
        4: load_config(8'd1, 8'd1, 8'd128, 8'd128, 10'd512);
        default: load_config(8'd40, 8'd8, 8'd60, 8'd200, 10'd1);
      endcase
      case (phase / 2)
        0: begin
          sender_gap_pct     = 29;
          receiver_stall_pct = 63;
        end
        1: begin
          sender_gap_pct     = 63;
          receiver_stall_pct = 29;
        end
        default: begin
          sender_gap_pct     = 0;
          receiver_stall_pct = 0;
        end
      endcase
      target = scans_sent + PHASE_SCANS;
      while (scans_sent < target) play_gesture();
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) sb.report_mismatch("expected results never arrived");
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
